// File: rtl/irp_pkg.sv
// Shared constants, types and command/status bundles of the in-place record permuter.
package irp_pkg;

    localparam int DEPTH        = 64;
    localparam int RECORD_WIDTH = 32;

    localparam int AW     = $clog2(DEPTH);
    localparam int CFG_W  = 7;
    localparam int POS_W  = 6;
    localparam int WORD_W = 32;
    localparam int CNT_W  = ($clog2(DEPTH + 1) > CFG_W) ? $clog2(DEPTH + 1) : CFG_W;

    localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(64);

    typedef logic [AW-1:0]           addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [RECORD_WIDTH-1:0] rec_t;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_APPLY = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_code_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_item;
        logic ld_write;
        logic rd_issue;
        logic chk_issue;
        logic idx_clear;
        logic idx_inc;
        logic set_bad;
        logic start_issue;
        logic walk_begin;
        logic walk_issue;
        logic walk_step;
        logic res_load;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_code_t cmd;
        logic      in_err;
        logic      cnt_zero;
        logic      chk_bad;
        logic      idx_last;
        logic      start_skip;
        logic      walk_stop;
        logic      out_free;
    } dp_status_t;

endpackage

// File: rtl/irp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module irp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/irp_datapath.sv
// Datapath: record, order and visited memories, walk registers, result register.
module irp_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  irp_pkg::dp_cmd_t               cmd,
    output irp_pkg::dp_status_t            stat,
    input  logic                           cfg_wr,
    input  logic [irp_pkg::CFG_W-1:0]      cfg_data,
    input  logic [1:0]                     command,
    input  logic [irp_pkg::POS_W-1:0]      position,
    input  logic [irp_pkg::WORD_W-1:0]     record_word,
    input  logic [irp_pkg::POS_W-1:0]      source_index,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [irp_pkg::WORD_W-1:0]     read_record,
    output logic [irp_pkg::POS_W-1:0]      echo_position,
    output logic                           status
);

    logic [irp_pkg::CFG_W-1:0]  count_reg;
    irp_pkg::cnt_t              eff_cnt;
    irp_pkg::cmd_code_t         cmd_reg;
    logic [irp_pkg::POS_W-1:0]  pos_reg;
    logic [irp_pkg::WORD_W-1:0] word_reg;
    logic [irp_pkg::POS_W-1:0]  src_reg;
    irp_pkg::addr_t             idx_reg;
    irp_pkg::addr_t             cur_reg;
    irp_pkg::addr_t             nxt_reg;
    irp_pkg::rec_t              held_reg;
    logic                       bad_reg;
    logic                       out_valid_reg;
    logic [irp_pkg::WORD_W-1:0] read_record_reg;
    logic [irp_pkg::POS_W-1:0]  echo_reg;
    logic                       status_reg;

    logic                       rec_we;
    irp_pkg::addr_t             rec_waddr;
    irp_pkg::rec_t              rec_wdata;
    logic                       rec_re;
    irp_pkg::addr_t             rec_raddr;
    irp_pkg::rec_t              rec_rdata;
    logic                       ord_re;
    irp_pkg::addr_t             ord_raddr;
    irp_pkg::addr_t             ord_rdata;
    logic                       vis_we;
    irp_pkg::addr_t             vis_waddr;
    logic                       vis_wdata;
    logic                       vis_re;
    irp_pkg::addr_t             vis_raddr;
    logic                       vis_rdata;
    irp_pkg::addr_t             pos_addr;
    logic                       pos_bad;
    logic                       src_bad;
    logic                       in_err;
    logic                       out_free;

    assign eff_cnt = (irp_pkg::CNT_W'(count_reg) > irp_pkg::CNT_W'(irp_pkg::DEPTH))
                   ? irp_pkg::CNT_W'(irp_pkg::DEPTH) : irp_pkg::CNT_W'(count_reg);

    assign pos_addr = irp_pkg::AW'(pos_reg);
    assign pos_bad  = irp_pkg::CNT_W'(pos_reg) >= eff_cnt;
    assign src_bad  = irp_pkg::CNT_W'(src_reg) >= eff_cnt;
    assign in_err   = pos_bad || ((cmd_reg == irp_pkg::CMD_LOAD) && src_bad);
    assign out_free = !out_valid_reg || out_ready;

    // Memory port steering
    assign rec_we    = cmd.ld_write || cmd.walk_step;
    assign rec_waddr = cmd.ld_write ? pos_addr : cur_reg;
    assign rec_wdata = cmd.ld_write ? irp_pkg::RECORD_WIDTH'(word_reg)
                     : ((nxt_reg != idx_reg) ? rec_rdata : held_reg);
    assign rec_re    = cmd.rd_issue || cmd.start_issue || cmd.walk_issue;
    assign rec_raddr = cmd.rd_issue ? pos_addr : (cmd.start_issue ? idx_reg : nxt_reg);
    assign ord_re    = cmd.chk_issue || cmd.start_issue || cmd.walk_issue;
    assign ord_raddr = cmd.walk_issue ? nxt_reg : idx_reg;

    // Visited map: zero each entry in use during the order check, mark it on a walk step
    assign vis_we    = cmd.chk_issue || cmd.walk_step;
    assign vis_waddr = cmd.walk_step ? cur_reg : idx_reg;
    assign vis_wdata = cmd.walk_step;
    assign vis_re    = cmd.start_issue || cmd.walk_issue;
    assign vis_raddr = cmd.walk_issue ? nxt_reg : idx_reg;

    irp_ram #(.WIDTH(irp_pkg::RECORD_WIDTH), .DEPTH(irp_pkg::DEPTH)) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .re    (rec_re),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    irp_ram #(.WIDTH(irp_pkg::AW), .DEPTH(irp_pkg::DEPTH)) u_ord_ram (
        .clk   (clk),
        .we    (cmd.ld_write),
        .waddr (pos_addr),
        .wdata (irp_pkg::AW'(src_reg)),
        .re    (ord_re),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    irp_ram #(.WIDTH(1), .DEPTH(irp_pkg::DEPTH)) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (vis_re),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= irp_pkg::COUNT_RESET;
            held_reg      <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                count_reg <= cfg_data;
            end
            if (cmd.walk_begin)
            begin
                held_reg <= rec_rdata;
            end
            if (cmd.latch_item)
            begin
                bad_reg <= 1'b0;
            end
            else if (cmd.set_bad)
            begin
                bad_reg <= 1'b1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and walk pointers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            cmd_reg  <= irp_pkg::cmd_code_t'(command);
            pos_reg  <= position;
            word_reg <= record_word;
            src_reg  <= source_index;
        end
        if (cmd.idx_clear)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + irp_pkg::AW'(1);
        end
        if (cmd.walk_begin)
        begin
            cur_reg <= idx_reg;
            nxt_reg <= ord_rdata;
        end
        else if (cmd.walk_step)
        begin
            cur_reg <= nxt_reg;
            nxt_reg <= ord_rdata;
        end
        if (cmd.res_load)
        begin
            case (cmd_reg)
                irp_pkg::CMD_LOAD:
                begin
                    read_record_reg <= '0;
                    echo_reg        <= pos_reg;
                    status_reg      <= in_err;
                end
                irp_pkg::CMD_READ:
                begin
                    read_record_reg <= in_err ? '0 : irp_pkg::WORD_W'(rec_rdata);
                    echo_reg        <= pos_reg;
                    status_reg      <= in_err;
                end
                irp_pkg::CMD_APPLY:
                begin
                    read_record_reg <= '0;
                    echo_reg        <= '0;
                    status_reg      <= bad_reg;
                end
                default:
                begin
                    read_record_reg <= '0;
                    echo_reg        <= '0;
                    status_reg      <= 1'b0;
                end
            endcase
        end
    end

    // The entry marked in the current walk step is not yet in the map, so compare
    // the next position against the current one directly.
    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.in_err     = in_err;
        stat.cnt_zero   = (eff_cnt == '0);
        stat.chk_bad    = irp_pkg::CNT_W'(ord_rdata) >= eff_cnt;
        stat.idx_last   = irp_pkg::CNT_W'(idx_reg) == (eff_cnt - irp_pkg::CNT_W'(1));
        stat.start_skip = vis_rdata || (ord_rdata == idx_reg);
        stat.walk_stop  = vis_rdata || (nxt_reg == cur_reg);
        stat.out_free   = out_free;
    end

    assign out_valid     = out_valid_reg;
    assign read_record   = read_record_reg;
    assign echo_position = echo_reg;
    assign status        = status_reg;

endmodule

// File: rtl/irp_ctrl.sv
// Controller state machine: sequences load, read, order check and cycle walk.
module irp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  irp_pkg::dp_status_t stat,
    output irp_pkg::dp_cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DISPATCH = 9'b000000010,
        ST_CHK      = 9'b000000100,
        ST_CHK_W    = 9'b000001000,
        ST_START    = 9'b000010000,
        ST_START_W  = 9'b000100000,
        ST_WALK_RD  = 9'b001000000,
        ST_WALK_WR  = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_DONE;
                case (stat.cmd)
                    irp_pkg::CMD_LOAD:
                    begin
                        cmd.ld_write = !stat.in_err;
                    end
                    irp_pkg::CMD_READ:
                    begin
                        cmd.rd_issue = !stat.in_err;
                    end
                    irp_pkg::CMD_APPLY:
                    begin
                        if (!stat.cnt_zero)
                        begin
                            cmd.idx_clear = 1'b1;
                            state_next    = ST_CHK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_CHK:
            begin
                cmd.chk_issue = 1'b1;
                state_next    = ST_CHK_W;
            end
            ST_CHK_W:
            begin
                if (stat.chk_bad)
                begin
                    cmd.set_bad = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (stat.idx_last)
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = ST_START;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_CHK;
                end
            end
            ST_START:
            begin
                cmd.start_issue = 1'b1;
                state_next      = ST_START_W;
            end
            ST_START_W:
            begin
                if (!stat.start_skip)
                begin
                    cmd.walk_begin = 1'b1;
                    state_next     = ST_WALK_RD;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_WALK_RD:
            begin
                cmd.walk_issue = 1'b1;
                state_next     = ST_WALK_WR;
            end
            ST_WALK_WR:
            begin
                cmd.walk_step = 1'b1;
                if (!stat.walk_stop)
                begin
                    state_next = ST_WALK_RD;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/in_place_record_permuter_core.sv
// Top level of the in-place record permuter: controller plus datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------------------
//  in      | into core | in_valid / in_ready   | command, position, record_word, source_index
//  out     | from core | out_valid / out_ready | read_record, echo_position, status
//  cfg     | into core | cfg_valid / cfg_ready | cfg_data (record_count)
//
// Steps: load, read and unused commands go from input transfer to result transfer through
// dispatch, result load and result valid; a read uses one registered memory read.
// Apply runs the order check (an issue and a wait step per record), then an issue and
// a wait step per start position and a read and a write step per record moved by the
// cycle walk; every step is bound by the single read port of the record, order and
// visited memories. Reset clears the controller, the output valid flag and the held
// record and sets record_count to 64; the memories are not cleared. The order check
// zeroes the visited map entry by entry before the walk. A stalled result waits in the
// output register while the next item is already taken; cfg_ready is always high.
module in_place_record_permuter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    command,
    input  logic [irp_pkg::POS_W-1:0]     position,
    input  logic [irp_pkg::WORD_W-1:0]    record_word,
    input  logic [irp_pkg::POS_W-1:0]     source_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [irp_pkg::WORD_W-1:0]    read_record,
    output logic [irp_pkg::POS_W-1:0]     echo_position,
    output logic                          status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [irp_pkg::CFG_W-1:0]     cfg_data
);

    irp_pkg::dp_cmd_t    dp_cmd;
    irp_pkg::dp_status_t dp_stat;

    // Configuration is taken in every cycle; the register lives in the datapath.
    assign cfg_ready = 1'b1;

    irp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    irp_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .cfg_wr        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .command       (command),
        .position      (position),
        .record_word   (record_word),
        .source_index  (source_index),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .read_record   (read_record),
        .echo_position (echo_position),
        .status        (status)
    );

    // The input ready is low in the cycle after every transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while previous item still in progress");

    // A new result appears only as the controller returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result loaded without controller returning to idle");

    // A flagged result never carries record data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (read_record == '0))
        else $error("error result carries record data");

    // Load write and walk write never share the record write port.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_cmd.ld_write && dp_cmd.walk_step))
        else $error("record write port driven twice");

endmodule

// File: dv/in_place_record_permuter_core_tb.sv
// Testbench for in_place_record_permuter_core: directed and random traffic with a predictor.
`timescale 1ns / 1ps

module in_place_record_permuter_core_tb;

    // Receiver hold-off used to fill the core and stall its input.
    localparam int HOLD_CYCLES = 300;

    // Result fields in the order the core drives them.
    typedef struct packed {
        logic [irp_pkg::WORD_W-1:0] rd_word;
        logic [irp_pkg::POS_W-1:0]  echo;
        logic                       flag;
    } permuter_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [1:0]                 command = irp_pkg::CMD_NONE;
    logic [irp_pkg::POS_W-1:0]  position = '0;
    logic [irp_pkg::WORD_W-1:0] record_word = '0;
    logic [irp_pkg::POS_W-1:0]  source_index = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [irp_pkg::WORD_W-1:0] read_record;
    logic [irp_pkg::POS_W-1:0]  echo_position;
    logic                       status;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [irp_pkg::CFG_W-1:0]  cfg_data = '0;

    // Predictor state: the store, the order table, which positions hold a written
    // entry, and the count register as last written.
    logic [irp_pkg::RECORD_WIDTH-1:0] stored_records [irp_pkg::DEPTH];
    irp_pkg::addr_t                   order_entries [irp_pkg::DEPTH];
    bit                               loaded_mask [irp_pkg::DEPTH];
    logic [irp_pkg::CFG_W-1:0]        count_reg = irp_pkg::COUNT_RESET;

    // Results still owed by the core, oldest first.
    permuter_result_t pending_results[$];
    permuter_result_t want_result;

    int mismatch_count = 0;
    int item_total = 0;
    bit idling_on = 1'b1;
    bit hold_request = 1'b0;

    in_place_record_permuter_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .position      (position),
        .record_word   (record_word),
        .source_index  (source_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_record   (read_record),
        .echo_position (echo_position),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // The count register is capped at the store depth.
    function automatic int live_count();
        return (count_reg > irp_pkg::DEPTH) ? irp_pkg::DEPTH : int'(count_reg);
    endfunction

    function automatic bit all_loaded(input int n);
        int i;
        for (i = 0; i < n; i++)
            if (!loaded_mask[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Rearrange the store so that new[i] = old[order[i]], walking each cycle once with
    // one held record. A walk ends at the first visited position; the held record goes
    // back only when the walk closes on its start. Return the out-of-range flag.
    function automatic logic permute_in_place(input int n);
        bit                               seen [irp_pkg::DEPTH];
        logic [irp_pkg::RECORD_WIDTH-1:0] held;
        int                               i;
        int                               cur;
        int                               nxt;
        for (i = 0; i < n; i++)
            if (order_entries[i] >= n)
                return 1'b1;
        for (i = 0; i < irp_pkg::DEPTH; i++)
            seen[i] = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (seen[i] || order_entries[i] == i)
                continue;
            cur  = i;
            held = stored_records[cur];
            while (!seen[cur])
            begin
                nxt       = order_entries[cur];
                seen[cur] = 1'b1;
                stored_records[cur] = (nxt != i) ? stored_records[nxt] : held;
                cur = nxt;
            end
        end
        return 1'b0;
    endfunction

    // Advance the predictor by one accepted item and return the result it owes.
    function automatic permuter_result_t permuter_step(
        input irp_pkg::cmd_code_t         cmd,
        input irp_pkg::addr_t             pos,
        input logic [irp_pkg::WORD_W-1:0] word,
        input irp_pkg::addr_t             src
    );
        permuter_result_t r;
        int               n;
        r = '0;
        n = live_count();
        case (cmd)
            irp_pkg::CMD_LOAD:
            begin
                r.echo = pos;
                if (pos >= n || src >= n)
                    r.flag = 1'b1;
                else
                begin
                    stored_records[pos] = word[irp_pkg::RECORD_WIDTH-1:0];
                    order_entries[pos]  = src;
                    loaded_mask[pos]    = 1'b1;
                end
            end
            irp_pkg::CMD_APPLY:
                r.flag = permute_in_place(n);
            irp_pkg::CMD_READ:
            begin
                r.echo = pos;
                if (pos >= n)
                    r.flag = 1'b1;
                else
                    r.rd_word = irp_pkg::WORD_W'(stored_records[pos]);
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item and hold it until the transfer. Entered at a rising edge; valid
    // stays high into the next call unless a random gap drops it first.
    task automatic send_item(
        input irp_pkg::cmd_code_t         cmd,
        input irp_pkg::addr_t             pos,
        input logic [irp_pkg::WORD_W-1:0] word,
        input irp_pkg::addr_t             src
    );
        int               gap;
        permuter_result_t owed;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        position     <= pos;
        record_word  <= word;
        source_index <= src;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        owed = permuter_step(cmd, pos, word, src);
        pending_results.insert(pending_results.size(), owed);
        if (cmd != irp_pkg::CMD_NONE)
            item_total++;
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the count register while the core is idle.
    task automatic write_count(input logic [irp_pkg::CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        count_reg = value;
    endtask

    function automatic void shuffle_positions(output irp_pkg::addr_t arr [irp_pkg::DEPTH],
                                              input int n);
        int             i;
        int             j;
        irp_pkg::addr_t t;
        for (i = 0; i < irp_pkg::DEPTH; i++)
            arr[i] = irp_pkg::addr_t'(i);
        for (i = n - 1; i > 0; i--)
        begin
            j      = $urandom_range(0, i);
            t      = arr[i];
            arr[i] = arr[j];
            arr[j] = t;
        end
    endfunction

    // One item that touches no written entry: unused command, out-of-range read or load.
    task automatic send_noise(input int n);
        int pick;
        pick = (n < irp_pkg::DEPTH) ? $urandom_range(0, 3) : 0;
        case (pick)
            1:
                send_item(irp_pkg::CMD_READ,
                          irp_pkg::addr_t'($urandom_range(n, irp_pkg::DEPTH - 1)), $urandom,
                          irp_pkg::addr_t'($urandom));
            2:
                send_item(irp_pkg::CMD_LOAD,
                          irp_pkg::addr_t'($urandom_range(n, irp_pkg::DEPTH - 1)), $urandom,
                          irp_pkg::addr_t'($urandom));
            3:
                send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'($urandom), $urandom,
                          irp_pkg::addr_t'($urandom_range(n, irp_pkg::DEPTH - 1)));
            default:
                send_item(irp_pkg::CMD_NONE, irp_pkg::addr_t'($urandom), $urandom,
                          irp_pkg::addr_t'($urandom));
        endcase
    endtask

    // One phase at a given count: load every position in use (mostly a true permutation,
    // sometimes an order with repeats), apply, read back, with noise mixed in. Now and
    // then skip the reload so that entries left from a larger count get checked.
    task automatic run_phase(input logic [irp_pkg::CFG_W-1:0] value, input bit allow_idle);
        irp_pkg::addr_t order_pick [irp_pkg::DEPTH];
        irp_pkg::addr_t load_seq [irp_pkg::DEPTH];
        int             n;
        int             k;
        bit             scrambled;
        idling_on = allow_idle && ($urandom_range(0, 4) != 0);
        write_count(value);
        n = live_count();
        if (n == 0)
        begin
            repeat (6)
                send_item(irp_pkg::cmd_code_t'($urandom_range(0, 3)),
                          irp_pkg::addr_t'($urandom), $urandom, irp_pkg::addr_t'($urandom));
            return;
        end
        if (!all_loaded(n) || $urandom_range(0, 3) != 0)
        begin
            scrambled = ($urandom_range(0, 3) == 0);
            shuffle_positions(order_pick, n);
            shuffle_positions(load_seq, n);
            for (k = 0; k < n; k++)
            begin
                send_item(irp_pkg::CMD_LOAD, load_seq[k], $urandom,
                          scrambled ? irp_pkg::addr_t'($urandom_range(0, n - 1))
                                    : order_pick[load_seq[k]]);
                if ($urandom_range(0, 5) == 0)
                    send_noise(n);
            end
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'($urandom_range(0, n - 1)),
                          $urandom, irp_pkg::addr_t'($urandom_range(0, n - 1)));
        end
        repeat ($urandom_range(1, 2))
        begin
            send_item(irp_pkg::CMD_APPLY, irp_pkg::addr_t'($urandom), $urandom,
                      irp_pkg::addr_t'($urandom));
            repeat ($urandom_range(1, 6))
            begin
                send_item(irp_pkg::CMD_READ, irp_pkg::addr_t'($urandom_range(0, n - 1)),
                          $urandom, irp_pkg::addr_t'($urandom));
                if ($urandom_range(0, 5) == 0)
                    send_noise(n);
            end
        end
    endtask

    function automatic logic [irp_pkg::CFG_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return irp_pkg::CFG_W'($urandom_range(irp_pkg::DEPTH, 127));
        if (roll == 2)
            return irp_pkg::CFG_W'($urandom_range(13, irp_pkg::DEPTH - 1));
        return irp_pkg::CFG_W'($urandom_range(1, 12));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out-of-range load position, out-of-range source, out-of-range read and the unused command.
    task automatic test_range_checks();
        write_count(irp_pkg::CFG_W'(4));
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(4), 32'hFFFF_FFFF, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(0), 32'h0000_0000, irp_pkg::addr_t'(63));
        send_item(irp_pkg::CMD_READ, irp_pkg::addr_t'(63), 32'h0000_0000, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_NONE, irp_pkg::addr_t'(63), 32'hFFFF_FFFF, irp_pkg::addr_t'(63));
    endtask

    // One four-long cycle through the whole store.
    task automatic test_single_cycle();
        int k;
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(0), 32'h0000_0000, irp_pkg::addr_t'(2));
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(1), 32'hFFFF_FFFF, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(2), 32'hA5A5_A5A5, irp_pkg::addr_t'(3));
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(3), 32'h5A5A_5A5A, irp_pkg::addr_t'(1));
        send_item(irp_pkg::CMD_APPLY, irp_pkg::addr_t'(63), 32'hFFFF_FFFF, irp_pkg::addr_t'(63));
        for (k = 0; k < 4; k++)
            send_item(irp_pkg::CMD_READ, irp_pkg::addr_t'(k), 32'h0, irp_pkg::addr_t'(0));
    endtask

    // An order with a repeated entry and a fixed point: the second walk hits a
    // visited position and stops without putting its held record back.
    task automatic test_repeated_entries();
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(0), 32'h0000_0011, irp_pkg::addr_t'(3));
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(1), 32'h0000_0022, irp_pkg::addr_t'(1));
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(2), 32'h0000_0033, irp_pkg::addr_t'(3));
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(3), 32'h0000_0044, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_APPLY, irp_pkg::addr_t'(0), 32'h0, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_READ, irp_pkg::addr_t'(0), 32'h0, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_READ, irp_pkg::addr_t'(2), 32'h0, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_READ, irp_pkg::addr_t'(3), 32'h0, irp_pkg::addr_t'(0));
    endtask

    // Shrink the count below an order entry still held: apply must flag and leave
    // the store alone.
    task automatic test_bad_order();
        write_count(irp_pkg::CFG_W'(2));
        send_item(irp_pkg::CMD_APPLY, irp_pkg::addr_t'(0), 32'h0, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_READ, irp_pkg::addr_t'(0), 32'h0, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_READ, irp_pkg::addr_t'(1), 32'h0, irp_pkg::addr_t'(0));
    endtask

    // Count zero: loads and reads flag, apply reports ok.
    task automatic test_count_zero();
        write_count('0);
        send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(0), 32'h1234_5678, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_READ, irp_pkg::addr_t'(0), 32'h0, irp_pkg::addr_t'(0));
        send_item(irp_pkg::CMD_APPLY, irp_pkg::addr_t'(0), 32'h0, irp_pkg::addr_t'(0));
    endtask

    // Hold the receiver off for a long stretch while the sender keeps offering reads,
    // so the output register and the core fill and in_ready drops.
    task automatic test_output_stall();
        irp_pkg::addr_t perm [irp_pkg::DEPTH];
        int             k;
        bit             saved;
        write_count(irp_pkg::CFG_W'(6));
        shuffle_positions(perm, 6);
        for (k = 0; k < 6; k++)
            send_item(irp_pkg::CMD_LOAD, irp_pkg::addr_t'(k), $urandom, perm[k]);
        saved        = idling_on;
        idling_on    = 1'b0;
        hold_request = 1'b1;
        repeat (20)
            send_item(irp_pkg::CMD_READ, irp_pkg::addr_t'($urandom_range(0, 5)), $urandom,
                      irp_pkg::addr_t'($urandom));
        idling_on = saved;
        wait_idle();
    endtask

    // Count extremes first, then random counts, mostly small.
    task automatic test_random_traffic();
        logic [irp_pkg::CFG_W-1:0] extremes [6];
        int                        k;
        extremes = '{irp_pkg::CFG_W'(1), irp_pkg::CFG_W'(64), irp_pkg::CFG_W'(127),
                     irp_pkg::CFG_W'(0), irp_pkg::CFG_W'(2), irp_pkg::CFG_W'(3)};
        for (k = 0; k < 6; k++)
            run_phase(extremes[k], 1'b1);
        while (item_total < 900)
            run_phase(pick_count(), 1'b1);
    endtask

    // Close with back-to-back traffic and no idling on either side.
    task automatic test_steady_stream();
        run_phase(irp_pkg::CFG_W'(16), 1'b0);
        run_phase(irp_pkg::CFG_W'(5), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus the long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic note_mismatch(input string what, input permuter_result_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: read_record exp %h got %h, echo_position exp %0d got %0d, %s",
                     $time, what, want.rd_word, read_record, want.echo, echo_position,
                     $sformatf("status exp %0d got %0d", want.flag, status));
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                note_mismatch("result with nothing expected", '0);
            else
            begin
                want_result = pending_results.pop_front();
                if (read_record !== want_result.rd_word || echo_position !== want_result.echo
                    || status !== want_result.flag)
                    note_mismatch("result mismatch", want_result);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset once, run the tests in turn, then drain and judge
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_range_checks();
        test_single_cycle();
        test_repeated_entries();
        test_bad_order();
        test_count_zero();
        test_output_stall();
        test_random_traffic();
        test_steady_stream();
        wait_idle();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS in_place_record_permuter_core");
        else
            $display("FAIL in_place_record_permuter_core");
        $finish;
    end

    // Watchdog: well beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("FAIL in_place_record_permuter_core");
        $finish;
    end

endmodule

// File: filelist.f
rtl/irp_pkg.sv
rtl/irp_ram.sv
rtl/irp_datapath.sv
rtl/irp_ctrl.sv
rtl/in_place_record_permuter_core.sv
dv/in_place_record_permuter_core_tb.sv
